### hdl/sorting_network_partner_macros.svh
// ----------------------------------------------------------------------------
// Sorting network partner assertion macros
// Concurrent assertion wrappers on clk / rst_n; empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef SORTING_NETWORK_PARTNER_MACROS_SVH
`define SORTING_NETWORK_PARTNER_MACROS_SVH

`ifndef SYNTHESIS

`define SNP_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`define SNP_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`else

`define SNP_ASSERT(name, prop, msg)

`define SNP_ASSERT_IMP(name, ante, cons, msg)

`endif

`endif

### hdl/snp_pkg.sv
// ----------------------------------------------------------------------------
// Sorting network partner package
// Widths, codes, stage words and helper functions shared by the pipeline.
// ----------------------------------------------------------------------------
package snp_pkg;

  localparam int MAX_PARTICIPANTS = 1024;

  localparam int RANK_W    = 10;
  localparam int STAGE_W   = 11;
  localparam int STG_W     = 10;  // in-range stage numbers stay below 1024
  localparam int N_W       = 11;
  localparam int KIND_W    = 3;
  localparam int RES_W     = 2;
  localparam int VAL_W     = 11;
  localparam int LG_W      = 4;
  localparam int MAX_LG    = 10;
  localparam int PH_W      = 4;
  localparam int TBL_W     = 6;
  localparam int CFG_IDX_W = 1;

  // network kinds
  localparam logic [KIND_W-1:0] NET_HC_UP    = 3'd0;
  localparam logic [KIND_W-1:0] NET_HC_DOWN  = 3'd1;
  localparam logic [KIND_W-1:0] NET_ODD_EVEN = 3'd2;
  localparam logic [KIND_W-1:0] NET_BATCHER  = 3'd3;
  localparam logic [KIND_W-1:0] NET_BITONIC  = 3'd4;

  // result kinds
  localparam logic [RES_W-1:0] RES_PARTNER  = 2'd0;
  localparam logic [RES_W-1:0] RES_FINISHED = 2'd1;
  localparam logic [RES_W-1:0] RES_COUNT    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_NET_KIND     = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTICIPANTS = 1'b1;

  localparam logic [KIND_W-1:0] KIND_RESET = NET_HC_UP;
  localparam logic [N_W-1:0]    N_RESET    = N_W'(1024);

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [N_W-1:0]    n;      // clamped participant count
    logic [LG_W-1:0]   lg;     // floor(log2 n)
    logic [N_W-1:0]    count;  // stage count, zero means no stages
  } cfg_info_t;

  typedef struct packed {
    logic [PH_W-1:0] ph;   // merge phase
    logic [PH_W-1:0] off;  // step inside the phase
  } phase_t;

  // after classify
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [STG_W-1:0]  stage;
    logic [RES_W-1:0]  res_kind;
    logic [PH_W-1:0]   ph;
    logic [PH_W-1:0]   off;
  } a_t;

  // after mask build
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic              par;     // stage parity
    logic [RES_W-1:0]  res_kind;
    logic [RANK_W-1:0] flip;
    logic [RANK_W-1:0] bp;      // merge-exchange bit mask
    logic [RANK_W-1:0] bd;      // merge-exchange distance
    logic              r_is_p;
    logic              up;
  } b_t;

  // after partner select
  typedef struct packed {
    logic [RANK_W-1:0] rank;
    logic [RES_W-1:0]  res_kind;
    logic [VAL_W-1:0]  partner;
    logic              up;
  } c_t;

  function automatic logic [N_W-1:0] clamp_n(input logic [N_W-1:0] x);
    return (x > N_W'(MAX_PARTICIPANTS)) ? N_W'(MAX_PARTICIPANTS) : x;
  endfunction

  function automatic logic [LG_W-1:0] floor_log2(input logic [N_W-1:0] x);
    logic [LG_W-1:0] l;
    l = '0;
    for (int b = 1; b < N_W; b++) begin
      if (x[b]) l = LG_W'(b);
    end
    return l;
  endfunction

  function automatic logic [N_W-1:0] stage_count(input logic [KIND_W-1:0] kind,
                                                 input logic [N_W-1:0]    n,
                                                 input logic [LG_W-1:0]   lg);
    logic [7:0]     prod;
    logic [N_W-1:0] cnt;
    prod = 8'(lg) * (8'(lg) + 8'd1);
    case (kind) inside
      NET_HC_UP, NET_HC_DOWN: cnt = N_W'(lg);
      NET_ODD_EVEN: begin
        if (n > N_W'(2))   cnt = n;
        else if (n == '0)  cnt = '0;
        else               cnt = n - N_W'(1);
      end
      NET_BATCHER, NET_BITONIC: cnt = N_W'(prod >> 1);
      default: cnt = '0;
    endcase
    return cnt;
  endfunction

  // Triangular split: phase k covers k+1 stages starting at k(k+1)/2.
  function automatic phase_t stage_phase(input logic [TBL_W-1:0] s);
    phase_t          p;
    logic [TBL_W-1:0] base;
    p.ph = '0;
    base = '0;
    for (int k = 1; k <= MAX_LG; k++) begin
      if (s >= TBL_W'(k * (k + 1) / 2)) begin
        p.ph = PH_W'(k);
        base = TBL_W'(k * (k + 1) / 2);
      end
    end
    p.off = PH_W'(s - base);
    return p;
  endfunction

endpackage

### hdl/snp_cfg.sv
// ----------------------------------------------------------------------------
// Sorting network partner configuration registers
// Holds network kind and participant count with derived log2 and stage count.
// ----------------------------------------------------------------------------
module snp_cfg
  import snp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [N_W-1:0]       cfg_wdata,
  output cfg_info_t            info
);

  logic [KIND_W-1:0] kind_r, kind_nxt;
  logic [N_W-1:0]    n_r, n_nxt;
  logic [LG_W-1:0]   lg_r, lg_nxt;
  logic [N_W-1:0]    count_r, count_nxt;

  always_comb begin
    kind_nxt = kind_r;
    n_nxt    = n_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_NET_KIND:     kind_nxt = cfg_wdata[KIND_W-1:0];
        CFG_PARTICIPANTS: n_nxt    = clamp_n(cfg_wdata);
        default:          kind_nxt = kind_r;
      endcase
    end
    // derived values settle in the same edge as the write
    lg_nxt    = floor_log2(n_nxt);
    count_nxt = stage_count(kind_nxt, n_nxt, lg_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r  <= KIND_RESET;
      n_r     <= N_RESET;
      lg_r    <= floor_log2(N_RESET);
      count_r <= stage_count(KIND_RESET, N_RESET, floor_log2(N_RESET));
    end else begin
      kind_r  <= kind_nxt;
      n_r     <= n_nxt;
      lg_r    <= lg_nxt;
      count_r <= count_nxt;
    end
  end

  assign info.kind  = kind_r;
  assign info.n     = n_r;
  assign info.lg    = lg_r;
  assign info.count = count_r;

endmodule

### hdl/snp_decode.sv
// ----------------------------------------------------------------------------
// Sorting network partner classify stage
// Range checks on rank and stage, phase split of the stage number.
// ----------------------------------------------------------------------------
module snp_decode
  import snp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  cfg_info_t                 cfg,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  logic [RANK_W-1:0]         up_rank,
  input  logic signed [STAGE_W-1:0] up_stage,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output a_t                        dn_word
);

  logic   a_v_r;
  a_t     a_r, a_nxt;
  phase_t ph;

  always_comb begin
    ph          = stage_phase(up_stage[TBL_W-1:0]);
    a_nxt.rank  = up_rank;
    a_nxt.stage = up_stage[STG_W-1:0];
    a_nxt.ph    = ph.ph;
    a_nxt.off   = ph.off;
    if (cfg.count == '0 || {1'b0, up_rank} >= cfg.n) begin
      a_nxt.res_kind = RES_FINISHED;
    end else if (up_stage[STAGE_W-1]) begin
      a_nxt.res_kind = RES_COUNT;
    end else if ({1'b0, up_stage[STG_W-1:0]} >= cfg.count) begin
      a_nxt.res_kind = RES_FINISHED;
    end else begin
      a_nxt.res_kind = RES_PARTNER;
    end
  end

  assign up_ready = !a_v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
    end else if (up_ready) begin
      a_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      a_r <= a_nxt;
    end
  end

  assign dn_valid = a_v_r;
  assign dn_word  = a_r;

endmodule

### hdl/snp_mask.sv
// ----------------------------------------------------------------------------
// Sorting network partner mask stage
// Builds the flip mask, merge-exchange mask and distance, and direction bit.
// ----------------------------------------------------------------------------
module snp_mask
  import snp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cfg_info_t cfg,
  input  logic      up_valid,
  output logic      up_ready,
  input  a_t        up_word,
  output logic      dn_valid,
  input  logic      dn_ready,
  output b_t        dn_word
);

  logic            b_v_r;
  b_t              b_r, b_nxt;
  logic [LG_W-1:0] sel;
  logic [VAL_W-1:0] rank_sh;
  logic [RANK_W-1:0] bp;

  always_comb begin
    case (cfg.kind) inside
      NET_HC_UP:   sel = up_word.stage[LG_W-1:0];
      NET_HC_DOWN: sel = cfg.lg - LG_W'(1) - up_word.stage[LG_W-1:0];
      NET_BITONIC: sel = up_word.ph - up_word.off;
      default:     sel = '0;
    endcase

    // merge-exchange: p = top >> phase; first step has r = 0 and d = p
    bp = RANK_W'(1) << (cfg.lg - LG_W'(1) - up_word.ph);
    rank_sh = VAL_W'({1'b0, up_word.rank} >> (up_word.ph + PH_W'(1)));

    b_nxt.rank     = up_word.rank;
    b_nxt.par      = up_word.stage[0];
    b_nxt.res_kind = up_word.res_kind;
    b_nxt.flip     = RANK_W'(1) << sel;
    b_nxt.bp       = bp;
    b_nxt.r_is_p   = (up_word.off != '0);
    b_nxt.bd       = (up_word.off == '0) ? bp
                   : (RANK_W'(1) << (cfg.lg - up_word.off)) - bp;
    b_nxt.up       = (cfg.kind == NET_BITONIC) && rank_sh[0];
  end

  assign up_ready = !b_v_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_v_r <= 1'b0;
    end else if (up_ready) begin
      b_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      b_r <= b_nxt;
    end
  end

  assign dn_valid = b_v_r;
  assign dn_word  = b_r;

endmodule

### hdl/snp_partner.sv
// ----------------------------------------------------------------------------
// Sorting network partner select and output stages
// Picks the partner for the selected network, then forms the result word.
// ----------------------------------------------------------------------------
`include "sorting_network_partner_macros.svh"

module snp_partner
  import snp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_info_t         cfg,
  input  logic              up_valid,
  output logic              up_ready,
  input  b_t                up_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [RES_W-1:0]  out_result_kind,
  output logic [VAL_W-1:0]  out_value,
  output logic              out_partner_exists,
  output logic              out_up_direction
);

  logic              c_v_r;
  c_t                c_r, c_nxt;
  logic              c_ready;
  logic [VAL_W-1:0]  rank_ext, rank_inc, bd_ext, lo;
  logic              hit_up, lo_ok;

  logic              d_v_r;
  logic [RES_W-1:0]  kind_r, kind_nxt;
  logic [VAL_W-1:0]  value_r, value_nxt;
  logic              exists_r, exists_nxt;
  logic              up_r, up_nxt;
  logic              d_ready;
  logic [VAL_W-1:0]  c_rank_ext;

  // ---- partner select
  always_comb begin
    rank_ext = {1'b0, up_word.rank};
    rank_inc = rank_ext + VAL_W'(1);
    bd_ext   = {1'b0, up_word.bd};
    lo       = rank_ext - bd_ext;
    hit_up   = ((|(up_word.rank & up_word.bp)) == up_word.r_is_p);
    lo_ok    = (rank_ext >= bd_ext) && ((|(lo[RANK_W-1:0] & up_word.bp)) == up_word.r_is_p);

    case (cfg.kind) inside
      NET_HC_UP, NET_HC_DOWN, NET_BITONIC: begin
        c_nxt.partner = {1'b0, up_word.rank ^ up_word.flip};
      end
      NET_ODD_EVEN: begin
        // end participants clamp back onto themselves
        if (up_word.par == up_word.rank[0]) begin
          c_nxt.partner = (rank_inc < cfg.n) ? rank_inc : rank_ext;
        end else begin
          c_nxt.partner = (up_word.rank == '0) ? rank_ext : rank_ext - VAL_W'(1);
        end
      end
      NET_BATCHER: begin
        if (hit_up)     c_nxt.partner = rank_ext + bd_ext;
        else if (lo_ok) c_nxt.partner = lo;
        else            c_nxt.partner = cfg.n;
      end
      default: c_nxt.partner = rank_ext;
    endcase

    c_nxt.rank     = up_word.rank;
    c_nxt.res_kind = up_word.res_kind;
    c_nxt.up       = up_word.up;
  end

  assign up_ready = !c_v_r || c_ready;
  assign c_ready  = d_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c_v_r <= 1'b0;
    end else if (up_ready) begin
      c_v_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      c_r <= c_nxt;
    end
  end

  // ---- result word
  assign c_rank_ext = {1'b0, c_r.rank};

  always_comb begin
    kind_nxt = c_r.res_kind;
    case (c_r.res_kind)
      RES_PARTNER: begin
        value_nxt  = c_r.partner;
        exists_nxt = (c_r.partner != c_rank_ext) && (c_r.partner < cfg.n);
        up_nxt     = c_r.up;
      end
      RES_COUNT: begin
        value_nxt  = cfg.count;
        exists_nxt = 1'b0;
        up_nxt     = 1'b0;
      end
      default: begin
        value_nxt  = '0;
        exists_nxt = 1'b0;
        up_nxt     = 1'b0;
      end
    endcase
  end

  assign d_ready = !d_v_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d_v_r <= 1'b0;
    end else if (d_ready) begin
      d_v_r <= c_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (d_ready && c_v_r) begin
      kind_r   <= kind_nxt;
      value_r  <= value_nxt;
      exists_r <= exists_nxt;
      up_r     <= up_nxt;
    end
  end

  assign out_valid          = d_v_r;
  assign out_result_kind    = kind_r;
  assign out_value          = value_r;
  assign out_partner_exists = exists_r;
  assign out_up_direction   = up_r;

  // ---- checks
  `SNP_ASSERT_IMP(a_oe_neighbor, c_v_r && c_r.res_kind == RES_PARTNER && cfg.kind == NET_ODD_EVEN, c_r.partner == c_rank_ext || c_r.partner == c_rank_ext + 11'd1 || c_r.partner + 11'd1 == c_rank_ext, "odd-even partner not adjacent")
  `SNP_ASSERT(a_xor_one_bit, (c_v_r && c_r.res_kind == RES_PARTNER && (cfg.kind == NET_HC_UP || cfg.kind == NET_HC_DOWN || cfg.kind == NET_BITONIC)) |-> $onehot(c_r.partner ^ c_rank_ext), "partner differs in other than one bit")
  `SNP_ASSERT_IMP(a_up_bitonic, out_valid && out_up_direction, cfg.kind == NET_BITONIC && out_result_kind == RES_PARTNER, "direction bit outside bitonic partner word")
  `SNP_ASSERT_IMP(a_exists_range, out_valid && out_partner_exists, out_result_kind == RES_PARTNER && out_value < cfg.n, "partner flagged but not a valid partner")

endmodule

### hdl/sorting_network_partner.sv
// ----------------------------------------------------------------------------
// Sorting network partner
// Compare-exchange partner lookup for five sorting networks.
// ----------------------------------------------------------------------------
// Takes one word per clock and returns one result word for each, in order.
// The path is four register stages (classify, mask build, partner select,
// output register), each stalling independently on a valid/ready basis, so
// throughput stays at one word per cycle as long as out_ready is high. Write
// cfg_index 0 for the network kind and 1 for the participant count (clamped
// to 1024) only while no word is in flight; the derived log2 and stage count
// update in the same edge as the write.
module sorting_network_partner
  import snp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [N_W-1:0]            cfg_wdata,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [RANK_W-1:0]         in_rank,
  input  logic signed [STAGE_W-1:0] in_stage,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [RES_W-1:0]          out_result_kind,
  output logic [VAL_W-1:0]          out_value,
  output logic                      out_partner_exists,
  output logic                      out_up_direction
);

  cfg_info_t cfg;
  logic      a_valid, a_ready;
  a_t        a_word;
  logic      b_valid, b_ready;
  b_t        b_word;

  snp_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .info      (cfg)
  );

  snp_decode u_decode (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_rank  (in_rank),
    .up_stage (in_stage),
    .dn_valid (a_valid),
    .dn_ready (a_ready),
    .dn_word  (a_word)
  );

  snp_mask u_mask (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .up_valid (a_valid),
    .up_ready (a_ready),
    .up_word  (a_word),
    .dn_valid (b_valid),
    .dn_ready (b_ready),
    .dn_word  (b_word)
  );

  snp_partner u_partner (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg                (cfg),
    .up_valid           (b_valid),
    .up_ready           (b_ready),
    .up_word            (b_word),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_result_kind    (out_result_kind),
    .out_value          (out_value),
    .out_partner_exists (out_partner_exists),
    .out_up_direction   (out_up_direction)
  );

endmodule

### tb/sv/sorting_network_partner_chk.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorting network partner result checker
// Watches the config port and both channels, keeps its own copy of the
// registers, computes the expected partner word per accepted input word and
// compares every accepted result word against the oldest one outstanding.
// ----------------------------------------------------------------------------
module sorting_network_partner_chk
  import snp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [N_W-1:0]            cfg_wdata,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [RANK_W-1:0]         in_rank,
  input  logic signed [STAGE_W-1:0] in_stage,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [RES_W-1:0]          out_result_kind,
  input  logic [VAL_W-1:0]          out_value,
  input  logic                      out_partner_exists,
  input  logic                      out_up_direction,
  output int                        fail_count,
  output int                        outstanding
);

  typedef struct packed {
    logic [RES_W-1:0] res_kind;
    logic [VAL_W-1:0] value;
    logic             exists;
    logic             up;
  } partner_word_t;

  logic [KIND_W-1:0] net_kind;
  logic [N_W-1:0]    net_size;
  partner_word_t     expected_partners[$];
  partner_word_t     want;

  function automatic partner_word_t calc_partner(input logic [KIND_W-1:0]         kind,
                                                 input logic [N_W-1:0]            size,
                                                 input logic [RANK_W-1:0]         rank_in,
                                                 input logic signed [STAGE_W-1:0] stage_in);
    partner_word_t res;
    int n, lg, x, stages, rank, stg, partner, i, top, p, q, r, d;
    bit found, busy;
    res = '{RES_FINISHED, '0, 1'b0, 1'b0};
    n = int'(size);
    if (n > MAX_PARTICIPANTS) n = MAX_PARTICIPANTS;
    lg = 0;
    x = n;
    while (x > 1) begin
      x = x >> 1;
      lg++;
    end
    rank = int'(rank_in);
    stg  = int'(stage_in);
    case (kind)
      NET_HC_UP, NET_HC_DOWN:   stages = lg;
      NET_ODD_EVEN:             stages = (n <= 2) ? n - 1 : n;
      NET_BATCHER, NET_BITONIC: stages = lg * (lg + 1) / 2;
      default:                  stages = 0;
    endcase

    if (stages <= 0 || rank >= n) return res;
    if (stg < 0) begin
      res.res_kind = RES_COUNT;
      res.value    = VAL_W'(stages);
      return res;
    end
    if (stg >= stages) return res;

    partner = rank;
    case (kind)
      NET_HC_UP:   partner = rank ^ (1 << stg);
      NET_HC_DOWN: partner = rank ^ (1 << (stages - 1 - stg));
      NET_ODD_EVEN: begin
        partner = ((stg & 1) == (rank & 1)) ? rank + 1 : rank - 1;
        // end participants fall back onto themselves
        if (partner > n - 1) partner = n - 1;
        if (partner < 0) partner = 0;
      end
      NET_BATCHER: begin
        partner = -1;
        found   = 1'b0;
        top     = 1 << (lg - 1);
        p       = top;
        while (p > 0 && !found) begin
          q    = top;
          r    = 0;
          d    = p;
          busy = 1'b1;
          while (busy) begin
            if (stg <= 0) begin
              if ((rank & p) == r) partner = rank + d;
              else if (rank - d >= 0 && ((rank - d) & p) == r) partner = rank - d;
              else partner = n;  // no partner: report the count itself
              found = 1'b1;
              busy  = 1'b0;
            end else begin
              stg--;
              d    = q - p;
              q    = q / 2;
              r    = p;
              busy = (d != 0);
            end
          end
          p = p / 2;
        end
        if (partner < 0) return res;
      end
      default: begin  // bitonic: find merge phase i and step within it
        i = 0;
        while (i < lg && stg > i) begin
          i++;
          stg -= i;
        end
        res.up  = 1'((rank >> (i + 1)) & 1);
        partner = rank ^ (1 << (i - stg));
      end
    endcase

    res.res_kind = RES_PARTNER;
    res.value    = VAL_W'(partner);
    res.exists   = (partner != rank && partner < n);
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, exp_val);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      net_kind   = KIND_RESET;
      net_size   = N_RESET;
      fail_count = 0;
      expected_partners.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_NET_KIND:     net_kind = cfg_wdata[KIND_W-1:0];
          CFG_PARTICIPANTS: net_size = cfg_wdata;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_partners.size() == 0) begin
          report_mismatch("unexpected result word (queue size)", 1, 0);
        end else begin
          want = expected_partners.pop_front();
          if (out_result_kind !== want.res_kind)
            report_mismatch("result_kind", int'(out_result_kind), int'(want.res_kind));
          if (out_value !== want.value)
            report_mismatch("value", int'(out_value), int'(want.value));
          if (out_partner_exists !== want.exists)
            report_mismatch("partner_exists", int'(out_partner_exists), int'(want.exists));
          if (out_up_direction !== want.up)
            report_mismatch("up_direction", int'(out_up_direction), int'(want.up));
        end
      end
      if (in_valid && in_ready)
        expected_partners.push_back(calc_partner(net_kind, net_size, in_rank, in_stage));
    end
    outstanding <= expected_partners.size();
  end

endmodule

### tb/sv/sorting_network_partner_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Sorting network partner testbench
// Directed corner words for every network, then randomized phases across
// network kinds and participant counts with varying source idle and sink
// stall, including one long sink hold-off that backs up the pipeline.
// ----------------------------------------------------------------------------
module sorting_network_partner_tb;
  import snp_pkg::*;

  localparam int HOLD_CYCLES   = 300;
  localparam int QUIET_LIMIT   = 3000;
  localparam int RAND_PHASES   = 20;
  localparam int WORDS_PER_PH  = 30;
  localparam int DIRECTED_CNT  = 25;

  typedef struct packed {
    logic [KIND_W-1:0]         kind;
    logic [N_W-1:0]            n;
    logic [RANK_W-1:0]         rank;
    logic signed [STAGE_W-1:0] stage;
  } probe_t;

  logic                      clk = 1'b0;
  logic                      rst_n = 1'b0;
  logic                      cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index = '0;
  logic [N_W-1:0]            cfg_wdata = '0;
  logic                      in_valid = 1'b0;
  logic                      in_ready;
  logic [RANK_W-1:0]         in_rank = '0;
  logic signed [STAGE_W-1:0] in_stage = '0;
  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic [RES_W-1:0]          out_result_kind;
  logic [VAL_W-1:0]          out_value;
  logic                      out_partner_exists;
  logic                      out_up_direction;

  int                fail_count;
  int                outstanding;
  int                idle_pct = 0;
  int                stall_pct = 0;
  logic              hold_on = 1'b0;
  int                hold_cnt = 0;
  int                quiet = 0;
  logic [KIND_W-1:0] cur_kind = KIND_RESET;
  logic [N_W-1:0]    cur_n = N_RESET;

  // extremes, every network, and the named corner cases
  probe_t directed [DIRECTED_CNT] = '{
    '{NET_HC_UP,    11'd1024, 10'd0,    -11'sd1},
    '{NET_HC_UP,    11'd1024, 10'd1023, 11'sd9},
    '{NET_HC_UP,    11'd1024, 10'd1023, -11'sd1024},
    '{NET_HC_UP,    11'd1024, 10'd5,    11'sd10},
    '{NET_HC_DOWN,  11'd1024, 10'd0,    11'sd0},
    '{NET_HC_DOWN,  11'd1024, 10'd1023, 11'sd1023},
    '{NET_ODD_EVEN, 11'd1024, 10'd0,    11'sd1},
    '{NET_ODD_EVEN, 11'd1024, 10'd1023, 11'sd1},
    '{NET_ODD_EVEN, 11'd1024, 10'd0,    11'sd1023},
    '{NET_BATCHER,  11'd1024, 10'd0,    11'sd0},
    '{NET_BATCHER,  11'd1024, 10'd700,  11'sd54},
    '{NET_BATCHER,  11'd1024, 10'd1,    11'sd1},
    '{NET_BATCHER,  11'd1024, 10'd511,  11'sd20},
    '{NET_BITONIC,  11'd1024, 10'd1023, 11'sd54},
    '{NET_BITONIC,  11'd1024, 10'd6,    11'sd3},
    '{NET_BITONIC,  11'd1024, 10'd0,    -11'sd1},
    '{3'd5,         11'd1024, 10'd0,    11'sd0},
    '{3'd7,         11'd1024, 10'd3,    -11'sd1},
    '{NET_BATCHER,  11'd12,   10'd11,   11'sd3},
    '{NET_HC_UP,    11'd12,   10'd4,    11'sd3},
    '{NET_ODD_EVEN, 11'd0,    10'd0,    -11'sd1},
    '{NET_ODD_EVEN, 11'd1,    10'd0,    -11'sd1},
    '{NET_ODD_EVEN, 11'd2,    10'd1,    11'sd0},
    '{NET_BITONIC,  11'd2047, 10'd1023, -11'sd1},
    '{NET_HC_UP,    11'd1000, 10'd1010, 11'sd0}
  };

  sorting_network_partner dut (.*);

  sorting_network_partner_chk partner_chk (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // sink side; the one long hold-off lets the pipeline fill and stall in_ready
  always @(posedge clk) begin
    if (hold_on && hold_cnt < HOLD_CYCLES) begin
      out_ready <= 1'b0;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  task automatic set_idling(input int mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct <= 0;  end
      1: begin idle_pct = 68; stall_pct <= 0;  end
      2: begin idle_pct = 0;  stall_pct <= 68; end
      default: begin idle_pct = 20; stall_pct <= 20; end
    endcase
  endtask

  task automatic send_word(input logic [RANK_W-1:0] r, input logic signed [STAGE_W-1:0] s);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_rank  <= r;
    in_stage <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  task automatic apply_setting(input logic [KIND_W-1:0] k, input logic [N_W-1:0] n);
    wait_drained();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_NET_KIND;
    cfg_wdata <= N_W'(k);
    @(posedge clk);
    cfg_index <= CFG_PARTICIPANTS;
    cfg_wdata <= n;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_kind = k;
    cur_n    = n;
  endtask

  // highest stage worth asking for; one past the last stage on purpose, but odd-even caps it at 1023
  function automatic int stage_ceiling(input logic [KIND_W-1:0] k, input int n_eff);
    int lg;
    lg = (n_eff >= 1) ? $clog2(n_eff + 1) - 1 : 0;
    case (k)
      NET_ODD_EVEN:           return (n_eff > 1023) ? 1023 : n_eff;
      NET_HC_UP, NET_HC_DOWN: return lg;
      default:                return lg * (lg + 1) / 2;
    endcase
  endfunction

  initial begin
    logic [KIND_W-1:0]         fixed_kind [10];
    logic [N_W-1:0]            fixed_n [10];
    logic [KIND_W-1:0]         k;
    logic [N_W-1:0]            n;
    logic [RANK_W-1:0]         r;
    logic signed [STAGE_W-1:0] s;
    int                        n_eff, pick;

    fixed_kind = '{NET_BATCHER, NET_BITONIC, NET_ODD_EVEN, NET_HC_UP, NET_HC_DOWN,
                   NET_BATCHER, NET_ODD_EVEN, NET_BITONIC, NET_HC_DOWN, 3'd6};
    fixed_n    = '{11'd1024, 11'd1024, 11'd1024, 11'd1024, 11'd1024,
                   11'd2047, 11'd0, 11'd2, 11'd3, 11'd50};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(0);
    foreach (directed[i]) begin
      if (directed[i].kind != cur_kind || directed[i].n != cur_n)
        apply_setting(directed[i].kind, directed[i].n);
      send_word(directed[i].rank, directed[i].stage);
    end

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      if (ph < 10) begin
        k = fixed_kind[ph];
        n = fixed_n[ph];
      end else begin
        k    = ($urandom_range(9) < 8) ? KIND_W'($urandom_range(4)) : KIND_W'($urandom_range(7, 5));
        pick = $urandom_range(99);
        if (pick < 25)      n = 11'd1024;
        else if (pick < 45) n = N_W'($urandom_range(2047));
        else                n = N_W'($urandom_range(64, 1));
      end
      apply_setting(k, n);
      set_idling(ph % 4);
      if (ph == 0) hold_on <= 1'b1;
      n_eff = (int'(n) > MAX_PARTICIPANTS) ? MAX_PARTICIPANTS : int'(n);

      repeat (WORDS_PER_PH) begin
        if ($urandom_range(99) < 85 && n_eff > 0) r = RANK_W'($urandom_range(n_eff - 1));
        else                                      r = RANK_W'($urandom);
        pick = $urandom_range(99);
        if (pick < 8)       s = -11'sd1;
        else if (pick < 13) s = {1'b1, 10'($urandom)};
        else if (pick < 88) s = STAGE_W'($urandom_range(stage_ceiling(k, n_eff)));
        else                s = STAGE_W'($urandom);
        send_word(r, s);
      end
    end

    wait_drained();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+hdl
hdl/snp_pkg.sv
hdl/snp_cfg.sv
hdl/snp_decode.sv
hdl/snp_mask.sv
hdl/snp_partner.sv
hdl/sorting_network_partner.sv
tb/sv/sorting_network_partner_chk.sv
tb/sv/sorting_network_partner_tb.sv
